>>> rtl/ctsu_pkg.sv
// Shared types and constants for the collision triangle setup block.
// No dependencies; the top, front end, back end and testbench import this package.
`default_nettype none
package ctsu_pkg;

  localparam int MAX_TRIANGLES_DEF = 512;
  localparam int CACHE_DEPTH_DEF   = 64;
  localparam int JOB_DEPTH         = 2;

  localparam logic [1:0] FUNC_VERTEX = 2'd0;
  localparam logic [1:0] FUNC_TRI    = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  typedef struct packed {
    logic        [1:0]  func;
    logic        [5:0]  vertex_slot;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] coord_z;
    logic        [5:0]  index_a;
    logic        [5:0]  index_b;
    logic        [5:0]  index_c;
  } in_word_t;

  typedef struct packed {
    logic        [8:0]  triangle_slot;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [31:0] plane_offset;
    logic        [1:0]  dominant_axis;
    logic signed [15:0] box_min_x;
    logic signed [15:0] box_min_y;
    logic signed [15:0] box_min_z;
    logic signed [15:0] box_max_x;
    logic signed [15:0] box_max_y;
    logic signed [15:0] box_max_z;
  } out_word_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } vtx_t;

  typedef struct packed {
    logic [8:0] slot;
    vtx_t       a;
    vtx_t       b;
    vtx_t       c;
  } job_t;

endpackage
`default_nettype wire

>>> rtl/collision_triangle_setup_top.sv
// Collision triangle setup. In: push/full queue of command words.
// Out: empty/pop queue of triangle result words.
// Vertex words write the vertex cache and clear words zero the triangle
// count without blocking the input. A triangle word blocks the input while
// its three corners are read from the single cache read port and while it
// waits for room in the two-entry job queue, then passes as a job through
// that queue to the back end. The back end takes each triangle through the
// cross product on the shared multiplier, the squares, 32 square-root steps,
// three divisions (none when the length is zero) and the plane offset.
// Triangles past the buffer limit are dropped with no result word.
// Reset clears the triangle count, marks every cache slot as origin and
// empties both queues. While the receiver holds off pop, the result word
// waits, the back end stops after its current triangle, and the front end
// keeps taking words until the job queue fills. Uses ctsu_pkg.
`default_nettype none
module collision_triangle_setup_top
  import ctsu_pkg::*;
#(
  parameter int MAX_TRIANGLES = MAX_TRIANGLES_DEF,
  parameter int CACHE_DEPTH   = CACHE_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_push,
  output logic           in_full,
  input  wire in_word_t  in_word,
  output logic           out_empty,
  input  wire logic      out_pop,
  output out_word_t      out_word
);

  logic job_push, job_full, job_pop, job_empty;
  job_t job_in, job_out;

  ctsu_front #(
    .MAX_TRIANGLES (MAX_TRIANGLES),
    .CACHE_DEPTH   (CACHE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_word  (in_word),
    .job_push (job_push),
    .job_word (job_in),
    .job_full (job_full)
  );

  ctsu_fifo #(.WIDTH($bits(job_t)), .DEPTH(JOB_DEPTH)) u_jobq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wdata (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (job_out),
    .empty (job_empty)
  );

  ctsu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job_word  (job_out),
    .job_pop   (job_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire

>>> rtl/ctsu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ctsu_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/ctsu_front.sv
// Front end: takes input words, owns the vertex cache and triangle count,
// gathers three corners per triangle and pushes a job. Uses ctsu_pkg, ctsu_ram.
`default_nettype none
module ctsu_front
  import ctsu_pkg::*;
#(
  parameter int MAX_TRIANGLES = MAX_TRIANGLES_DEF,
  parameter int CACHE_DEPTH   = CACHE_DEPTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_push,
  output logic          in_full,
  input  wire in_word_t in_word,
  output logic          job_push,
  output job_t          job_word,
  input  wire logic     job_full
);

  localparam int AW = $clog2(CACHE_DEPTH);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_READ = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic [9:0]       count_r, count_nxt;
  logic [CACHE_DEPTH-1:0] valid_r;
  logic [5:0]       ia_r, ib_r, ic_r;
  logic [5:0]       rd_idx;
  logic             rd_ok_r;
  vtx_t             va_r, vb_r, vc_r;
  vtx_t             rd_vtx;
  logic [47:0]      rdata;
  logic             accept, we;

  assign accept  = in_push && !in_full;
  assign in_full = (state_r != F_IDLE);
  assign we = accept && (in_word.func == FUNC_VERTEX)
              && (32'(in_word.vertex_slot) < CACHE_DEPTH);

  always_comb begin
    case (cnt_r)
      2'd0:    rd_idx = ia_r;
      2'd1:    rd_idx = ib_r;
      default: rd_idx = ic_r;
    endcase
  end

  ctsu_ram #(.WIDTH(48), .DEPTH(CACHE_DEPTH)) u_cache (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(in_word.vertex_slot)),
    .wdata ({in_word.coord_x, in_word.coord_y, in_word.coord_z}),
    .raddr (AW'(rd_idx)),
    .rdata (rdata)
  );

  // never-written or out-of-range corners read as the origin
  assign rd_vtx = rd_ok_r ? vtx_t'(rdata) : '0;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    count_nxt = count_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept && in_word.func == FUNC_CLEAR) begin
          count_nxt = '0;
        end else if (accept && in_word.func == FUNC_TRI
                     && 32'(count_r) < MAX_TRIANGLES) begin
          state_nxt = F_READ;
          cnt_nxt   = '0;
        end
      end
      F_READ: begin
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!job_full) begin
          state_nxt = F_IDLE;
          count_nxt = count_r + 10'd1;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cnt_r   <= '0;
      count_r <= '0;
      valid_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      count_r <= count_nxt;
      if (we) begin
        valid_r[AW'(in_word.vertex_slot)] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && accept) begin
      ia_r <= in_word.index_a;
      ib_r <= in_word.index_b;
      ic_r <= in_word.index_c;
    end
    rd_ok_r <= (32'(rd_idx) < CACHE_DEPTH) && valid_r[AW'(rd_idx)];
    if (state_r == F_READ) begin
      case (cnt_r)
        2'd1:    va_r <= rd_vtx;
        2'd2:    vb_r <= rd_vtx;
        2'd3:    vc_r <= rd_vtx;
        default: ;
      endcase
    end
  end

  assign job_push      = (state_r == F_PUSH) && !job_full;
  assign job_word.slot = count_r[8:0];
  assign job_word.a    = va_r;
  assign job_word.b    = vb_r;
  assign job_word.c    = vc_r;

endmodule
`default_nettype wire

>>> rtl/ctsu_fifo.sv
// Small register queue carrying triangle jobs from front to back.
// No dependencies.
`default_nettype none
module ctsu_fifo #(
  parameter int WIDTH = 153,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [PW:0]      cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == (PW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH-1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH-1)) ? '0 : rd_ptr_r + PW'(1);
      end
      cnt_r <= cnt_r + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

>>> rtl/ctsu_back.sv
// Back end: cross product, square root, normalize and plane offset on one
// shared multiplier and iterative units; holds the result word. Uses ctsu_pkg.
`default_nettype none
module ctsu_back
  import ctsu_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      job_empty,
  input  wire job_t      job_word,
  output logic           job_pop,
  output logic           out_empty,
  input  wire logic      out_pop,
  output out_word_t      out_word
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CROSS = 4'd1;
  localparam logic [3:0] ST_MAG   = 4'd2;
  localparam logic [3:0] ST_SQ    = 4'd3;
  localparam logic [3:0] ST_SQRT  = 4'd4;
  localparam logic [3:0] ST_DIVS  = 4'd5;
  localparam logic [3:0] ST_DIV   = 4'd6;
  localparam logic [3:0] ST_DOT   = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  logic [3:0]         state_r;
  logic [4:0]         cnt_r;
  logic [1:0]         comp_r;
  logic               out_valid_r;
  logic [8:0]         slot_r;
  logic signed [15:0] v0_r [3];
  logic signed [15:0] bmin_r [3];
  logic signed [15:0] bmax_r [3];
  logic signed [16:0] e1_r [3];
  logic signed [16:0] e2_r [3];
  logic signed [63:0] p_r;
  logic signed [34:0] c_r [3];
  logic [29:0]        sm_r [3];
  logic [2:0]         cneg_r;
  logic [1:0]         axis_r;
  logic [61:0]        sum_r;
  logic [63:0]        n_r, res_r;
  logic [45:0]        num_r;
  logic [33:0]        rem_r;
  logic [15:0]        q_r;
  logic signed [15:0] nrm_r [3];
  logic signed [33:0] dot_r;

  logic signed [31:0] ma, mb;
  logic [2:0]         op;
  logic [33:0]        mag [3];
  logic [33:0]        maxm;
  logic [2:0]         sh;
  logic [63:0]        bitv, trial;
  logic [31:0]        len;
  logic [45:0]        num;
  logic [34:0]        remsh, den;
  logic               qbit;
  logic [15:0]        qfin;
  vtx_t               ja, jb, jc;

  assign op  = cnt_r[3:1];
  assign len = res_r[31:0];
  assign ja  = job_word.a;
  assign jb  = job_word.b;
  assign jc  = job_word.c;

  // operand select for the shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      ST_CROSS: begin
        case (op)
          3'd0:    begin ma = 32'(e1_r[1]); mb = 32'(e2_r[2]); end
          3'd1:    begin ma = 32'(e1_r[2]); mb = 32'(e2_r[1]); end
          3'd2:    begin ma = 32'(e1_r[2]); mb = 32'(e2_r[0]); end
          3'd3:    begin ma = 32'(e1_r[0]); mb = 32'(e2_r[2]); end
          3'd4:    begin ma = 32'(e1_r[0]); mb = 32'(e2_r[1]); end
          default: begin ma = 32'(e1_r[1]); mb = 32'(e2_r[0]); end
        endcase
      end
      ST_SQ: begin
        ma = $signed({2'b00, sm_r[op[1:0]]});
        mb = $signed({2'b00, sm_r[op[1:0]]});
      end
      ST_DOT: begin
        ma = 32'(nrm_r[op[1:0]]);
        mb = 32'(v0_r[op[1:0]]);
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k] = c_r[k][34] ? 34'(-c_r[k]) : 34'(c_r[k]);
    end
    maxm = (mag[0] > mag[1]) ? mag[0] : mag[1];
    maxm = (mag[2] > maxm) ? mag[2] : maxm;
    // smallest shift leaving every magnitude below 2^30
    if (maxm[33])      sh = 3'd4;
    else if (maxm[32]) sh = 3'd3;
    else if (maxm[31]) sh = 3'd2;
    else if (maxm[30]) sh = 3'd1;
    else               sh = 3'd0;
  end

  assign bitv  = 64'(1) << {cnt_r, 1'b0};
  assign trial = res_r + bitv;

  assign num   = {1'b0, sm_r[comp_r], 15'b0} + 46'(len);
  assign den   = {2'b00, len, 1'b0};
  assign remsh = {rem_r, num_r[cnt_r[3:0] + 4'd0]};
  assign qbit  = (remsh >= den);
  assign qfin  = {q_r[14:0], qbit};

  assign job_pop   = (state_r == ST_IDLE) && !job_empty && !out_valid_r;
  assign out_empty = !out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      comp_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (job_pop) begin
            state_r <= ST_CROSS;
            cnt_r   <= '0;
          end
        end
        ST_CROSS: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd11) state_r <= ST_MAG;
        end
        ST_MAG: begin
          state_r <= ST_SQ;
          cnt_r   <= '0;
        end
        ST_SQ: begin
          if (cnt_r == 5'd5) begin
            state_r <= ST_SQRT;
            cnt_r   <= 5'd31;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        ST_SQRT: begin
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd0) begin
            state_r <= ST_DIVS;
            comp_r  <= '0;
          end
        end
        ST_DIVS: begin
          if (len == '0) begin
            comp_r <= comp_r + 2'd1;
            if (comp_r == 2'd2) begin
              state_r <= ST_DOT;
              cnt_r   <= '0;
            end
          end else begin
            state_r <= ST_DIV;
            cnt_r   <= 5'd15;
          end
        end
        ST_DIV: begin
          if (cnt_r == 5'd0) begin
            comp_r <= comp_r + 2'd1;
            if (comp_r == 2'd2) begin
              state_r <= ST_DOT;
              cnt_r   <= '0;
            end else begin
              state_r <= ST_DIVS;
            end
          end else begin
            cnt_r <= cnt_r - 5'd1;
          end
        end
        ST_DOT: begin
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd5) state_r <= ST_OUT;
        end
        ST_OUT: begin
          state_r     <= ST_IDLE;
          out_valid_r <= 1'b1;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    p_r <= ma * mb;
    case (state_r)
      ST_IDLE: begin
        if (job_pop) begin
          slot_r <= job_word.slot;
          v0_r[0] <= ja.x; v0_r[1] <= ja.y; v0_r[2] <= ja.z;
          e1_r[0] <= 17'(jb.x) - 17'(ja.x);
          e1_r[1] <= 17'(jb.y) - 17'(ja.y);
          e1_r[2] <= 17'(jb.z) - 17'(ja.z);
          e2_r[0] <= 17'(jc.x) - 17'(ja.x);
          e2_r[1] <= 17'(jc.y) - 17'(ja.y);
          e2_r[2] <= 17'(jc.z) - 17'(ja.z);
          bmin_r[0] <= (ja.x < jb.x ? (ja.x < jc.x ? ja.x : jc.x) : (jb.x < jc.x ? jb.x : jc.x));
          bmin_r[1] <= (ja.y < jb.y ? (ja.y < jc.y ? ja.y : jc.y) : (jb.y < jc.y ? jb.y : jc.y));
          bmin_r[2] <= (ja.z < jb.z ? (ja.z < jc.z ? ja.z : jc.z) : (jb.z < jc.z ? jb.z : jc.z));
          bmax_r[0] <= (ja.x > jb.x ? (ja.x > jc.x ? ja.x : jc.x) : (jb.x > jc.x ? jb.x : jc.x));
          bmax_r[1] <= (ja.y > jb.y ? (ja.y > jc.y ? ja.y : jc.y) : (jb.y > jc.y ? jb.y : jc.y));
          bmax_r[2] <= (ja.z > jb.z ? (ja.z > jc.z ? ja.z : jc.z) : (jb.z > jc.z ? jb.z : jc.z));
          for (int k = 0; k < 3; k++) c_r[k] <= '0;
        end
      end
      ST_CROSS: begin
        // odd cycles fold the previous product into its component
        if (cnt_r[0]) begin
          case (op)
            3'd0:    c_r[0] <= c_r[0] + 35'(p_r);
            3'd1:    c_r[0] <= c_r[0] - 35'(p_r);
            3'd2:    c_r[1] <= c_r[1] + 35'(p_r);
            3'd3:    c_r[1] <= c_r[1] - 35'(p_r);
            3'd4:    c_r[2] <= c_r[2] + 35'(p_r);
            default: c_r[2] <= c_r[2] - 35'(p_r);
          endcase
        end
      end
      ST_MAG: begin
        for (int k = 0; k < 3; k++) begin
          sm_r[k]   <= 30'(mag[k] >> sh);
          cneg_r[k] <= c_r[k][34];
        end
        if (mag[0] > mag[1] && mag[0] > mag[2])      axis_r <= AXIS_X;
        else if (mag[1] > mag[0] && mag[1] > mag[2]) axis_r <= AXIS_Y;
        else if (mag[2] > mag[0] && mag[2] > mag[1]) axis_r <= AXIS_Z;
        else                                         axis_r <= AXIS_NONE;
        sum_r <= '0;
      end
      ST_SQ: begin
        if (cnt_r[0]) sum_r <= sum_r + 62'(p_r);
        if (cnt_r == 5'd5) begin
          n_r   <= {2'b00, sum_r + 62'(p_r)};
          res_r <= '0;
        end
      end
      ST_SQRT: begin
        if (n_r >= trial) begin
          n_r   <= n_r - trial;
          res_r <= (res_r >> 1) + bitv;
        end else begin
          res_r <= res_r >> 1;
        end
      end
      ST_DIVS: begin
        num_r <= num;
        rem_r <= 34'(num[45:16]);
        q_r   <= '0;
        if (len == '0) nrm_r[comp_r] <= '0;
      end
      ST_DIV: begin
        rem_r <= qbit ? 34'(remsh - den) : 34'(remsh);
        q_r   <= qfin;
        if (cnt_r == 5'd0) begin
          nrm_r[comp_r] <= cneg_r[comp_r] ? -$signed(qfin) : $signed(qfin);
          dot_r <= '0;
        end
      end
      ST_DOT: begin
        if (cnt_r == 5'd0) dot_r <= '0;
        else if (cnt_r[0]) dot_r <= dot_r + 34'(p_r);
      end
      ST_OUT: begin
        out_word.triangle_slot <= slot_r;
        out_word.normal_x      <= nrm_r[0];
        out_word.normal_y      <= nrm_r[1];
        out_word.normal_z      <= nrm_r[2];
        out_word.plane_offset  <= 32'(-dot_r);
        out_word.dominant_axis <= axis_r;
        out_word.box_min_x     <= bmin_r[0];
        out_word.box_min_y     <= bmin_r[1];
        out_word.box_min_z     <= bmin_r[2];
        out_word.box_max_x     <= bmax_r[0];
        out_word.box_max_y     <= bmax_r[1];
        out_word.box_max_z     <= bmax_r[2];
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> dv/tb_collision_triangle_setup_top.sv
// Testbench for collision_triangle_setup_top: directed and random command words,
// self-checking against a built-in triangle setup predictor.
// Depends on ctsu_pkg and the RTL of the block only.
`timescale 1ns / 1ps
module tb_collision_triangle_setup_top;
  import ctsu_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 300;
  localparam int IW             = $bits(in_word_t);

  logic      clk;
  logic      rst_n;
  logic      in_push;
  logic      in_full;
  in_word_t  in_word;
  logic      out_empty;
  logic      out_pop;
  out_word_t out_word;

  collision_triangle_setup_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_word(in_word),
    .out_empty(out_empty), .out_pop(out_pop), .out_word(out_word)
  );

  // predictor state
  vtx_t        cache_mdl [CACHE_DEPTH_DEF];
  int unsigned tri_count;
  out_word_t   expected_q[$];

  int errors;
  int results_seen;
  int words_sent;
  int idle_cycles;
  bit no_idle;
  bit done;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic vtx_t corner(logic [5:0] idx);
    if (idx < CACHE_DEPTH_DEF) return cache_mdl[idx];
    return '0;
  endfunction

  // Updates model state; pushes a result word for each accepted triangle.
  function automatic void predict_setup(in_word_t w);
    vtx_t            v [3];
    longint          p [3][3];
    longint          e1 [3];
    longint          e2 [3];
    longint          cr [3];
    longint unsigned mag [3];
    longint unsigned sm [3];
    longint unsigned maxm, sum, len, q;
    longint          nrm [3];
    longint          dot;
    longint          lo, hi;
    out_word_t       r;
    int              s;
    if (w.func == FUNC_VERTEX) begin
      if (w.vertex_slot < CACHE_DEPTH_DEF)
        cache_mdl[w.vertex_slot] = '{w.coord_x, w.coord_y, w.coord_z};
      return;
    end
    if (w.func == FUNC_CLEAR) begin
      tri_count = 0;
      return;
    end
    if (w.func != FUNC_TRI || tri_count >= MAX_TRIANGLES_DEF) return;
    v[0] = corner(w.index_a);
    v[1] = corner(w.index_b);
    v[2] = corner(w.index_c);
    for (int j = 0; j < 3; j++) begin
      p[j][0] = v[j].x;
      p[j][1] = v[j].y;
      p[j][2] = v[j].z;
    end
    for (int k = 0; k < 3; k++) begin
      lo = p[0][k];
      hi = p[0][k];
      for (int j = 1; j < 3; j++) begin
        if (p[j][k] < lo) lo = p[j][k];
        if (p[j][k] > hi) hi = p[j][k];
      end
      case (k)
        0: begin r.box_min_x = lo[15:0]; r.box_max_x = hi[15:0]; end
        1: begin r.box_min_y = lo[15:0]; r.box_max_y = hi[15:0]; end
        default: begin r.box_min_z = lo[15:0]; r.box_max_z = hi[15:0]; end
      endcase
      e1[k] = p[1][k] - p[0][k];
      e2[k] = p[2][k] - p[0][k];
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    maxm = 0;
    for (int k = 0; k < 3; k++) begin
      mag[k] = (cr[k] < 0) ? -cr[k] : cr[k];
      if (mag[k] > maxm) maxm = mag[k];
    end
    if (mag[0] > mag[1] && mag[0] > mag[2])      r.dominant_axis = AXIS_X;
    else if (mag[1] > mag[0] && mag[1] > mag[2]) r.dominant_axis = AXIS_Y;
    else if (mag[2] > mag[0] && mag[2] > mag[1]) r.dominant_axis = AXIS_Z;
    else                                         r.dominant_axis = AXIS_NONE;
    s = 0;
    while ((maxm >> s) >= (64'd1 << 30)) s++;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      sm[k] = mag[k] >> s;
      sum += sm[k] * sm[k];
    end
    len = floor_sqrt(sum);
    for (int k = 0; k < 3; k++) begin
      if (len == 0) begin
        nrm[k] = 0;
      end else begin
        q = (sm[k] * 32768 + len) / (2 * len);
        nrm[k] = (cr[k] < 0) ? -longint'(q) : longint'(q);
      end
    end
    dot = nrm[0] * p[0][0] + nrm[1] * p[0][1] + nrm[2] * p[0][2];
    dot = -dot;
    r.triangle_slot = tri_count[8:0];
    r.normal_x = nrm[0][15:0];
    r.normal_y = nrm[1][15:0];
    r.normal_z = nrm[2][15:0];
    r.plane_offset = dot[31:0];
    expected_q.push_back(r);
    tri_count = (tri_count + 1) & 10'h3FF;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  // Sends one word; predicts at the accepting edge. Push stays high until the
  // next word or an idle cycle takes it down.
  task automatic send_word(in_word_t w);
    while (!no_idle && $urandom_range(99) < 19) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict_setup(w);
    words_sent++;
    @(negedge clk);
  endtask

  function automatic in_word_t vertex_word(logic [5:0] slot, logic [15:0] x, logic [15:0] y,
                                           logic [15:0] z);
    in_word_t w;
    w = IW'({$urandom, $urandom, $urandom});
    w.func = FUNC_VERTEX;
    w.vertex_slot = slot;
    w.coord_x = x;
    w.coord_y = y;
    w.coord_z = z;
    return w;
  endfunction

  function automatic in_word_t tri_word(logic [5:0] a, logic [5:0] b, logic [5:0] c);
    in_word_t w;
    w = IW'({$urandom, $urandom, $urandom});
    w.func = FUNC_TRI;
    w.index_a = a;
    w.index_b = b;
    w.index_c = c;
    return w;
  endfunction

  function automatic in_word_t clear_word();
    in_word_t w;
    w = IW'({$urandom, $urandom, $urandom});
    w.func = FUNC_CLEAR;
    return w;
  endfunction

  // pop side: random stalls, check in arrival order
  always @(negedge clk) begin
    if (rst_n) out_pop <= no_idle || ($urandom_range(99) >= 19);
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      out_word_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("ERROR %0t: result word with nothing expected", $time);
      end else begin
        want = expected_q.pop_front();
        if (out_word.triangle_slot != want.triangle_slot)
          report_mismatch("triangle_slot", out_word.triangle_slot, want.triangle_slot);
        if (out_word.normal_x != want.normal_x)
          report_mismatch("normal_x", out_word.normal_x, want.normal_x);
        if (out_word.normal_y != want.normal_y)
          report_mismatch("normal_y", out_word.normal_y, want.normal_y);
        if (out_word.normal_z != want.normal_z)
          report_mismatch("normal_z", out_word.normal_z, want.normal_z);
        if (out_word.plane_offset != want.plane_offset)
          report_mismatch("plane_offset", out_word.plane_offset, want.plane_offset);
        if (out_word.dominant_axis != want.dominant_axis)
          report_mismatch("dominant_axis", out_word.dominant_axis, want.dominant_axis);
        if (out_word.box_min_x != want.box_min_x)
          report_mismatch("box_min_x", out_word.box_min_x, want.box_min_x);
        if (out_word.box_min_y != want.box_min_y)
          report_mismatch("box_min_y", out_word.box_min_y, want.box_min_y);
        if (out_word.box_min_z != want.box_min_z)
          report_mismatch("box_min_z", out_word.box_min_z, want.box_min_z);
        if (out_word.box_max_x != want.box_max_x)
          report_mismatch("box_max_x", out_word.box_max_x, want.box_max_x);
        if (out_word.box_max_y != want.box_max_y)
          report_mismatch("box_max_y", out_word.box_max_y, want.box_max_y);
        if (out_word.box_max_z != want.box_max_z)
          report_mismatch("box_max_z", out_word.box_max_z, want.box_max_z);
      end
    end
  end

  // watchdog: cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || !rst_n || done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired, %0d results outstanding", expected_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic test_extremes();
    send_word(vertex_word(6'd0, 16'h8000, 16'h8000, 16'h8000));
    send_word(vertex_word(6'd63, 16'h7FFF, 16'h7FFF, 16'h8000));
    send_word(vertex_word(6'd1, 16'h7FFF, 16'h8000, 16'h7FFF));
    send_word(tri_word(6'd0, 6'd63, 6'd1));
    send_word(tri_word(6'd1, 6'd0, 6'd63));
    send_word(vertex_word(6'd2, 16'h8000, 16'h7FFF, 16'h7FFF));
    send_word(tri_word(6'd63, 6'd1, 6'd2));
    // never-written slot reads as zero origin
    send_word(tri_word(6'd40, 6'd0, 6'd63));
  endtask

  task automatic test_special_cases();
    // degenerate: repeated corner gives zero normal
    send_word(tri_word(6'd1, 6'd1, 6'd2));
    // collinear corners
    send_word(vertex_word(6'd3, 16'd1, 16'd1, 16'd1));
    send_word(vertex_word(6'd4, 16'd2, 16'd2, 16'd2));
    send_word(vertex_word(6'd5, 16'd3, 16'd3, 16'd3));
    send_word(tri_word(6'd3, 6'd4, 6'd5));
    // axis ties: normal along (1,1,0) and (1,1,1)
    send_word(vertex_word(6'd6, 16'd0, 16'd0, 16'd0));
    send_word(vertex_word(6'd7, 16'd1, -16'sd1, 16'd0));
    send_word(vertex_word(6'd8, 16'd0, 16'd0, 16'd1));
    send_word(tri_word(6'd6, 6'd7, 6'd8));
    send_word(vertex_word(6'd9, 16'd1, 16'd0, 16'd0));
    send_word(vertex_word(6'd10, 16'd0, 16'd1, 16'd0));
    send_word(vertex_word(6'd11, 16'd0, 16'd0, 16'd1));
    send_word(tri_word(6'd9, 6'd10, 6'd11));
    send_word(tri_word(6'd11, 6'd10, 6'd9));
    // unused func code three is ignored
    begin
      in_word_t w;
      w = tri_word(6'd9, 6'd10, 6'd11);
      w.func = 2'd3;
      send_word(w);
    end
    send_word(clear_word());
    send_word(tri_word(6'd9, 6'd11, 6'd10));
  endtask

  // fill the buffer from an empty count, push past it, then clear
  task automatic test_buffer_full();
    send_word(clear_word());
    while (tri_count < MAX_TRIANGLES_DEF)
      send_word(tri_word(6'($urandom_range(63)), 6'($urandom_range(63)),
                         6'($urandom_range(63))));
    repeat (4) send_word(tri_word(6'($urandom_range(63)), 6'($urandom_range(63)), 6'd0));
    send_word(clear_word());
  endtask

  task automatic test_random(int count);
    int n;
    in_word_t w;
    n = 0;
    while (n < count) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          w = vertex_word(6'($urandom_range(63)), 16'($urandom), 16'($urandom),
                          16'($urandom));
          // small coordinates now and then, to reach near-degenerate triangles
          if ($urandom_range(3) == 0) begin
            w.coord_x = $signed(5'($urandom));
            w.coord_y = $signed(5'($urandom));
            w.coord_z = $signed(5'($urandom));
          end
        end
        4, 5, 6, 7, 8: w = tri_word(6'($urandom_range(63)), 6'($urandom_range(63)),
                                    6'($urandom_range(63)));
        default: begin
          w = IW'({$urandom, $urandom, $urandom});
          if (w.func == FUNC_CLEAR && $urandom_range(3) != 0) w.func = FUNC_TRI;
        end
      endcase
      send_word(w);
      n++;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_word = '0;
    out_pop = 1'b0;
    errors = 0;
    results_seen = 0;
    words_sent = 0;
    idle_cycles = 0;
    done = 1'b0;
    no_idle = 1'b0;
    tri_count = 0;
    foreach (cache_mdl[i]) cache_mdl[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_extremes();
    test_special_cases();
    test_random(200);
    no_idle = 1'b1;
    test_random(100);
    no_idle = 1'b0;
    test_buffer_full();
    test_random(150);
    in_push <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    done = 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d command words and %0d triangle results,", words_sent, results_seen);
    $display("including extreme corners, ties, degenerate and buffer-full triangles");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
